// ===== rtl/llt_pkg.sv =====
// Lease lock table: shared types, codes and sizing constants.
// Used by llt_mem, llt_ctrl and lease_lock_table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package llt_pkg;

	localparam int unsigned NUM_LOCKS = 4;  // 1 .. 256
	localparam int unsigned IDX_W     = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int unsigned LIDX_W    = 8;
	localparam int unsigned ID_W      = 32;
	localparam int unsigned TIME_W    = 32;

	localparam logic [LIDX_W:0] NUM_LOCKS_L = (LIDX_W + 1)'(NUM_LOCKS);

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LAST_IDX = idx_t'(NUM_LOCKS - 1);

	typedef enum logic [1:0] {
		KIND_ACQUIRE     = 2'd0,
		KIND_RELEASE     = 2'd1,
		KIND_RELEASE_ALL = 2'd2,
		KIND_NEW_INST    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ARG   = 2'd1,
		ST_SELF_HELD = 2'd2,
		ST_HELD      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP
	} state_t;

	// one table entry; the held flag lives in flops next to the controller
	typedef struct packed {
		logic [ID_W-1:0]   owner;
		logic [TIME_W-1:0] expiry;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/lease_lock_table.sv =====
// Lease lock table top level: ties the command sequencer to the entry memory.
// Depends on llt_pkg, llt_mem and llt_ctrl.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  command  | start in, busy out     | kind, owner_id, lock_index, lease_time, now_seconds
//  result   | done out (one cycle)   | status, granted_index, new_instance
//
// Release by index, new instance and out-of-range acquire finish without leaving idle:
// done rises in the cycle after the accept and busy stays low.
// Acquire reads the entry memory on accept (read data is registered), then does
// the check and write-back in the execute state; busy is high during execute.
// Release-all makes one memory read per entry.
// Reset clears the held flags, so no memory clearing pass is needed.
// The receiver cannot stall: each result word is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module lease_lock_table (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [1:0]                  kind,
	input  wire  [llt_pkg::ID_W-1:0]    owner_id,
	input  wire  [llt_pkg::LIDX_W-1:0]  lock_index,
	input  wire  [llt_pkg::TIME_W-1:0]  lease_time,
	input  wire  [llt_pkg::TIME_W-1:0]  now_seconds,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [llt_pkg::LIDX_W-1:0]  granted_index,
	output logic [llt_pkg::ID_W-1:0]    new_instance
);

	llt_pkg::mem_req_t mem_req;
	llt_pkg::entry_t   rd_data;

	llt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.owner_id      (owner_id),
		.lock_index    (lock_index),
		.lease_time    (lease_time),
		.now_seconds   (now_seconds),
		.done          (done),
		.status        (status),
		.granted_index (granted_index),
		.new_instance  (new_instance),
		.mem_req       (mem_req),
		.rd_data       (rd_data)
	);

	llt_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

// ===== rtl/llt_mem.sv =====
// Lease lock table: owner/expiry storage, one write and one read port,
// read data registered. Depends on llt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module llt_mem (
	input  wire                    clk,
	input  wire llt_pkg::mem_req_t req,
	output llt_pkg::entry_t        rd_data
);

	llt_pkg::entry_t mem [llt_pkg::NUM_LOCKS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/llt_ctrl.sv =====
// Lease lock table: command sequencer, held flags, instance counter and
// result registers. Depends on llt_pkg; drives llt_mem through mem_req_t.
`timescale 1ns / 1ps
`default_nettype none

module llt_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [1:0]                   kind,
	input  wire  [llt_pkg::ID_W-1:0]     owner_id,
	input  wire  [llt_pkg::LIDX_W-1:0]   lock_index,
	input  wire  [llt_pkg::TIME_W-1:0]   lease_time,
	input  wire  [llt_pkg::TIME_W-1:0]   now_seconds,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [llt_pkg::LIDX_W-1:0]   granted_index,
	output logic [llt_pkg::ID_W-1:0]     new_instance,
	output llt_pkg::mem_req_t            mem_req,
	input  wire  llt_pkg::entry_t        rd_data
);

	llt_pkg::state_t state_q, state_d;
	logic [llt_pkg::NUM_LOCKS-1:0] held_q, held_d;
	logic [llt_pkg::ID_W-1:0]      inst_cnt_q, inst_cnt_d;
	llt_pkg::idx_t                 ptr_q, ptr_d;

	// request word latched on accept
	logic [llt_pkg::ID_W-1:0]   owner_q;
	llt_pkg::idx_t              idx_q;
	logic [llt_pkg::TIME_W-1:0] lease_q;
	logic [llt_pkg::TIME_W-1:0] now_q;

	logic                       done_q, res_vld_d;
	llt_pkg::status_t           status_q, status_d;
	logic [llt_pkg::LIDX_W-1:0] granted_q, granted_d;
	logic [llt_pkg::ID_W-1:0]   inst_q, inst_d;

	logic            accept;
	logic            in_range;
	llt_pkg::kind_t  kind_in;
	llt_pkg::idx_t   lidx;
	logic            live;

	assign busy     = (state_q != llt_pkg::S_IDLE);
	assign accept   = start && !busy;
	assign kind_in  = llt_pkg::kind_t'(kind);
	assign in_range = ({1'b0, lock_index} < llt_pkg::NUM_LOCKS_L);
	assign lidx     = lock_index[llt_pkg::IDX_W-1:0];
	// held and unexpired; rd_data holds the entry read on accept
	assign live     = held_q[idx_q] && (rd_data.expiry > now_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			llt_pkg::S_IDLE: begin
				if (accept) begin
					if (kind_in == llt_pkg::KIND_ACQUIRE && in_range) begin
						state_d = llt_pkg::S_EXEC;
					end else if (kind_in == llt_pkg::KIND_RELEASE_ALL) begin
						state_d = llt_pkg::S_SWEEP;
					end
				end
			end
			llt_pkg::S_EXEC: begin
				state_d = llt_pkg::S_IDLE;
			end
			llt_pkg::S_SWEEP: begin
				if (ptr_q == llt_pkg::LAST_IDX) begin
					state_d = llt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = llt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_req    = '0;
		held_d     = held_q;
		inst_cnt_d = inst_cnt_q;
		ptr_d      = ptr_q;
		res_vld_d  = 1'b0;
		status_d   = llt_pkg::ST_OK;
		granted_d  = '0;
		inst_d     = '0;
		case (state_q)
			llt_pkg::S_IDLE: begin
				if (accept) begin
					case (kind_in)
						llt_pkg::KIND_ACQUIRE: begin
							if (in_range) begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = lidx;
							end else begin
								res_vld_d = 1'b1;
								status_d  = llt_pkg::ST_BAD_ARG;
							end
						end
						llt_pkg::KIND_RELEASE: begin
							res_vld_d = 1'b1;
							if (in_range) begin
								held_d[lidx] = 1'b0;
							end else begin
								status_d = llt_pkg::ST_BAD_ARG;
							end
						end
						llt_pkg::KIND_RELEASE_ALL: begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = '0;
							ptr_d           = '0;
						end
						llt_pkg::KIND_NEW_INST: begin
							res_vld_d  = 1'b1;
							inst_cnt_d = inst_cnt_q + 1'b1;
							inst_d     = inst_cnt_q + 1'b1;
						end
						default: begin
							res_vld_d = 1'b0;
						end
					endcase
				end
			end
			llt_pkg::S_EXEC: begin
				res_vld_d = 1'b1;
				if (live) begin
					status_d = (rd_data.owner == owner_q) ? llt_pkg::ST_SELF_HELD
						: llt_pkg::ST_HELD;
				end else begin
					mem_req.wr_en          = 1'b1;
					mem_req.wr_addr        = idx_q;
					mem_req.wr_data.owner  = owner_q;
					mem_req.wr_data.expiry = now_q + lease_q;
					held_d[idx_q]          = 1'b1;
					granted_d              = llt_pkg::LIDX_W'(idx_q);
				end
			end
			llt_pkg::S_SWEEP: begin
				// entry ptr_q is on rd_data; fetch the next one behind it
				if (held_q[ptr_q] && rd_data.owner == owner_q) begin
					held_d[ptr_q] = 1'b0;
				end
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == llt_pkg::LAST_IDX) begin
					res_vld_d = 1'b1;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = ptr_q + 1'b1;
				end
			end
			default: begin
				res_vld_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= llt_pkg::S_IDLE;
			held_q     <= '0;
			inst_cnt_q <= '0;
			ptr_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			held_q     <= held_d;
			inst_cnt_q <= inst_cnt_d;
			ptr_q      <= ptr_d;
			done_q     <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			owner_q <= owner_id;
			idx_q   <= lidx;
			lease_q <= lease_time;
			now_q   <= now_seconds;
		end
		status_q  <= status_d;
		granted_q <= granted_d;
		inst_q    <= inst_d;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign new_instance  = inst_q;

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == llt_pkg::S_EXEC |=> state_q != llt_pkg::S_EXEC)
		else $error("acquire stayed in execute for more than one cycle");

	a_grant_sets_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == llt_pkg::S_EXEC && !live) |=> held_q[$past(idx_q)])
		else $error("granted lock not marked held");

	a_refusal_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != llt_pkg::ST_OK) |-> (granted_q == '0 && inst_q == '0))
		else $error("refused word carries a grant or instance");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == llt_pkg::S_EXEC) |=> done_q)
		else $error("acquire finished without a result strobe");

	a_no_write_outside_exec: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> state_q == llt_pkg::S_EXEC)
		else $error("table write outside acquire execute");

endmodule

`default_nettype wire
